/* src/radiative_surface_temp_solver_unit_defines.svh */
// Assertion macros shared by the surface temperature solver modules.
`ifndef RADIATIVE_SURFACE_TEMP_SOLVER_UNIT_DEFINES_SVH
`define RADIATIVE_SURFACE_TEMP_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RSTS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSTS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RSTS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* src/rsts_pkg.sv */
// Shared types and constants of the surface temperature solver.
package rsts_pkg;
    localparam int TEMP_W = 28;
    localparam logic [TEMP_W-1:0] TEMP_MAX = {TEMP_W{1'b1}};
    localparam logic [39:0] SIGMA_Q64 = 40'd1045930388979;
    localparam logic [1:0] REG_CONDUCTIVITY = 2'd0;
    localparam logic [1:0] REG_HALF_CELL_DEPTH = 2'd1;
    localparam logic [1:0] REG_ABSORBED_FLUX = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_KD_INIT   = 4'd1,   // load kd division
        OP_DIV       = 4'd2,   // one division bit
        OP_KD_DONE   = 4'd3,   // store kd
        OP_T2        = 4'd4,
        OP_MUL_INIT  = 4'd5,   // load the selected product operands
        OP_MUL       = 4'd6,   // one shift-add multiply bit
        OP_MUL_DONE  = 4'd7,   // store the selected product
        OP_SUM       = 4'd8,
        OP_STEP_INIT = 4'd9,
        OP_UPDATE    = 4'd10,
        OP_LOAD      = 4'd11
    } op_t;

    // Product formed by the shared multiplier.
    typedef enum logic [1:0] {
        MUL_ST2  = 2'd0,
        MUL_RAD  = 2'd1,
        MUL_DRAD = 2'd2,
        MUL_KT   = 2'd3
    } mul_sel_t;

    typedef struct packed {
        op_t      op;
        mul_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic slope_zero;
        logic step_zero;
        logic mul_zero;
    } stat_t;
endpackage

/* src/rsts_datapath.sv */
// Datapath: registers, a shared shift-add multiplier and a shared restoring divider.
`include "radiative_surface_temp_solver_unit_defines.svh"
module rsts_datapath #(
    parameter int TEMP_FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rsts_pkg::cmd_t             cmd,
    input  logic [rsts_pkg::TEMP_W-1:0] ti_in,
    input  logic [23:0]                k_cfg,
    input  logic [31:0]                d_cfg,
    input  logic [11:0]                q_cfg,
    output rsts_pkg::stat_t            stat,
    output logic [rsts_pkg::TEMP_W-1:0] t_out
);
    localparam int TW = rsts_pkg::TEMP_W;
    localparam int F = TEMP_FRAC_BITS;

    logic [TW-1:0] ti_reg, t_reg, t_next;
    logic [2*TW-1:0] t2_reg;
    logic [63:0] st2_reg;
    logic [63:0] kd_reg;
    logic [127:0] rad_reg, drad_reg, kterm_reg;
    logic [127:0] mag_reg, slope_reg;
    logic down_reg;
    logic [127:0] num_reg, rem_reg, quo_reg, den_reg;
    logic [127:0] mul_a_reg, acc_reg;
    logic [63:0] mul_b_reg;

    logic [127:0] acc_st2, acc_rad, acc_drad, acc_kt, pos, neg, slope, rem_sh, rem_sub;
    logic [2*TW-1:0] t_sq;
    logic [TW-1:0] dt;
    logic ge_ti;
    logic [31:0] depth;

    assign depth = (d_cfg == 32'd0) ? 32'd1 : d_cfg;
    assign ge_ti = t_reg >= ti_reg;
    assign dt = ge_ti ? t_reg - ti_reg : ti_reg - t_reg;
    assign t_sq = (2*TW)'(t_reg) * (2*TW)'(t_reg);
    assign acc_st2 = acc_reg >> (16 + 2 * F);
    assign acc_rad = acc_reg >> (2 * F);
    assign acc_drad = acc_reg >> (F - 2);
    assign acc_kt = acc_reg >> (F - 8);
    assign slope = drad_reg + (128'(kd_reg) << 8);
    assign pos = ge_ti ? rad_reg + kterm_reg : rad_reg;
    assign neg = ge_ti ? (128'(q_cfg) << 48) : (128'(q_cfg) << 48) + kterm_reg;
    assign rem_sh = {rem_reg[126:0], num_reg[127]};
    assign rem_sub = rem_sh - den_reg;

    always_comb begin
        logic [127:0] st;
        st = (quo_reg > 128'(rsts_pkg::TEMP_MAX)) ? 128'(rsts_pkg::TEMP_MAX) + 128'd1 : quo_reg;
        if (down_reg) begin
            t_next = (st[TW:0] >= {1'b0, t_reg}) ? '0 : t_reg - st[TW-1:0];
        end else begin
            t_next = ({1'b0, t_reg} + st[TW:0] > {1'b0, rsts_pkg::TEMP_MAX}) ?
                     rsts_pkg::TEMP_MAX : t_reg + st[TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            rsts_pkg::OP_LOAD: begin
                ti_reg <= ti_in;
                t_reg <= ti_in;
            end
            rsts_pkg::OP_KD_INIT: begin
                num_reg <= 128'(k_cfg) << 40;
                den_reg <= 128'(depth);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            rsts_pkg::OP_DIV: begin
                num_reg <= num_reg << 1;
                if (rem_sh >= den_reg) begin
                    rem_reg <= rem_sub;
                    quo_reg <= {quo_reg[126:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[126:0], 1'b0};
                end
            end
            rsts_pkg::OP_KD_DONE: kd_reg <= quo_reg[63:0];
            rsts_pkg::OP_T2: t2_reg <= t_sq;
            rsts_pkg::OP_MUL_INIT: begin
                acc_reg <= '0;
                case (cmd.sel)
                    rsts_pkg::MUL_ST2: begin
                        mul_a_reg <= 128'(rsts_pkg::SIGMA_Q64);
                        mul_b_reg <= 64'(t2_reg);
                    end
                    rsts_pkg::MUL_RAD: begin
                        mul_a_reg <= 128'(st2_reg);
                        mul_b_reg <= 64'(t2_reg);
                    end
                    rsts_pkg::MUL_DRAD: begin
                        mul_a_reg <= 128'(st2_reg);
                        mul_b_reg <= 64'(t_reg);
                    end
                    rsts_pkg::MUL_KT: begin
                        mul_a_reg <= 128'(kd_reg);
                        mul_b_reg <= 64'(dt);
                    end
                    default: begin
                        mul_a_reg <= '0;
                        mul_b_reg <= '0;
                    end
                endcase
            end
            rsts_pkg::OP_MUL: begin
                if (mul_b_reg[0]) acc_reg <= acc_reg + mul_a_reg;
                mul_a_reg <= mul_a_reg << 1;
                mul_b_reg <= mul_b_reg >> 1;
            end
            rsts_pkg::OP_MUL_DONE: begin
                case (cmd.sel)
                    rsts_pkg::MUL_ST2: st2_reg <= acc_st2[63:0];
                    rsts_pkg::MUL_RAD: rad_reg <= acc_rad;
                    rsts_pkg::MUL_DRAD: drad_reg <= acc_drad;
                    rsts_pkg::MUL_KT: kterm_reg <= acc_kt;
                    default: ;
                endcase
            end
            rsts_pkg::OP_SUM: begin
                slope_reg <= slope;
                down_reg <= pos >= neg;
                mag_reg <= (pos >= neg) ? pos - neg : neg - pos;
            end
            rsts_pkg::OP_STEP_INIT: begin
                num_reg <= mag_reg << F;
                den_reg <= slope_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            rsts_pkg::OP_UPDATE: t_reg <= t_next;
            default: ;
        endcase
    end

    assign stat.slope_zero = (slope_reg == '0);
    assign stat.step_zero = (quo_reg == '0);
    assign stat.mul_zero = (mul_b_reg == '0);
    assign t_out = t_reg;

    `RSTS_ASSERT_NEXT(a_load_t, aclk, aresetn, cmd.op == rsts_pkg::OP_LOAD, t_reg == $past(ti_in))
    `RSTS_ASSERT_NEXT(a_mul_clear, aclk, aresetn, cmd.op == rsts_pkg::OP_MUL_INIT, acc_reg == '0)
    `RSTS_ASSERT_NEXT(a_init_clear, aclk, aresetn, cmd.op == rsts_pkg::OP_STEP_INIT, rem_reg == '0)
endmodule

/* src/rsts_ctrl.sv */
// Controller: sequences kd division and the Newton steps.
`include "radiative_surface_temp_solver_unit_defines.svh"
module rsts_ctrl #(
    parameter int MAX_ITERATIONS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rsts_pkg::stat_t stat,
    output rsts_pkg::cmd_t  cmd,
    output logic            done_flag
);
    localparam int IW = $clog2(MAX_ITERATIONS + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001, S_KDI = 12'b000000000010,
        S_KDD = 12'b000000000100, S_KDS = 12'b000000001000,
        S_T2 = 12'b000000010000, S_MLI = 12'b000000100000,
        S_MUL = 12'b000001000000, S_SUM = 12'b000010000000,
        S_CHK = 12'b000100000000, S_DIV = 12'b001000000000,
        S_UPD = 12'b010000000000, S_OUT = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    rsts_pkg::mul_sel_t sel_reg, sel_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [IW-1:0] it_reg, it_next;
    logic done_reg, done_next;

    always_comb begin
        state_next = state_reg;
        sel_next = sel_reg;
        cnt_next = cnt_reg;
        it_next = it_reg;
        done_next = done_reg;
        cmd.op = rsts_pkg::OP_NONE;
        cmd.sel = sel_reg;
        case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd.op = rsts_pkg::OP_LOAD;
                it_next = '0;
                done_next = 1'b0;
                state_next = S_KDI;
            end
            S_KDI: begin
                cmd.op = rsts_pkg::OP_KD_INIT;
                cnt_next = '0;
                state_next = S_KDD;
            end
            S_KDD: begin
                cmd.op = rsts_pkg::OP_DIV;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd127) state_next = S_KDS;
            end
            S_KDS: begin
                cmd.op = rsts_pkg::OP_KD_DONE;
                state_next = S_T2;
            end
            S_T2: begin
                if (it_reg == IW'(MAX_ITERATIONS)) state_next = S_OUT;
                else begin
                    cmd.op = rsts_pkg::OP_T2;
                    sel_next = rsts_pkg::MUL_ST2;
                    state_next = S_MLI;
                end
            end
            S_MLI: begin
                cmd.op = rsts_pkg::OP_MUL_INIT;
                state_next = S_MUL;
            end
            S_MUL: begin
                // The multiply ends once the shifted multiplier runs out of set bits.
                if (stat.mul_zero) begin
                    cmd.op = rsts_pkg::OP_MUL_DONE;
                    case (sel_reg)
                        rsts_pkg::MUL_ST2: begin
                            sel_next = rsts_pkg::MUL_RAD;
                            state_next = S_MLI;
                        end
                        rsts_pkg::MUL_RAD: begin
                            sel_next = rsts_pkg::MUL_DRAD;
                            state_next = S_MLI;
                        end
                        rsts_pkg::MUL_DRAD: begin
                            sel_next = rsts_pkg::MUL_KT;
                            state_next = S_MLI;
                        end
                        default: state_next = S_SUM;
                    endcase
                end else begin
                    cmd.op = rsts_pkg::OP_MUL;
                end
            end
            S_SUM: begin
                cmd.op = rsts_pkg::OP_SUM;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (stat.slope_zero) state_next = S_OUT;
                else begin
                    cmd.op = rsts_pkg::OP_STEP_INIT;
                    cnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op = rsts_pkg::OP_DIV;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd127) state_next = S_UPD;
            end
            S_UPD: begin
                if (stat.step_zero) begin
                    done_next = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.op = rsts_pkg::OP_UPDATE;
                    it_next = it_reg + IW'(1);
                    state_next = S_T2;
                end
            end
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg <= rsts_pkg::MUL_ST2;
            cnt_reg <= '0;
            it_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg <= sel_next;
            cnt_reg <= cnt_next;
            it_reg <= it_next;
            done_reg <= done_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign done_flag = done_reg;

    `RSTS_ASSERT_IMPL(a_excl, aclk, aresetn, 1'b1, !(in_ready && out_valid))
    `RSTS_ASSERT_IMPL(a_it_lim, aclk, aresetn, 1'b1, it_reg <= IW'(MAX_ITERATIONS))
    `RSTS_ASSERT_NEXT(a_accept, aclk, aresetn, in_valid && in_ready, state_reg == S_KDI)
endmodule

/* src/radiative_surface_temp_solver_unit.sv */
// Radiative surface temperature solver: Newton iteration on the surface balance.
// kd is formed first by a restoring division; each Newton step then runs a division
// plus four shift-add products, which set the rate.
// At most MAX_ITERATIONS steps are run.
// One item at a time; a result holds until transferred, then input reopens.
// Synchronous active-low reset restores register defaults and idles the controller.
module radiative_surface_temp_solver_unit #(
    parameter int MAX_ITERATIONS = 32,
    parameter int TEMP_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [27:0] s_inner_temp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [27:0] m_surface_temp,
    output logic        m_converged
);
    logic [23:0] k_reg;
    logic [31:0] d_reg;
    logic [11:0] q_reg;
    rsts_pkg::cmd_t cmd;
    rsts_pkg::stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 24'd196608;
            d_reg <= 32'd65536;
            q_reg <= 12'd114;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rsts_pkg::REG_CONDUCTIVITY: k_reg <= cfg_data[23:0];
                rsts_pkg::REG_HALF_CELL_DEPTH: d_reg <= cfg_data;
                rsts_pkg::REG_ABSORBED_FLUX: q_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    rsts_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .stat(stat), .cmd(cmd),
        .done_flag(m_converged)
    );

    rsts_datapath #(.TEMP_FRAC_BITS(TEMP_FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .ti_in(s_inner_temp),
        .k_cfg(k_reg), .d_cfg(d_reg), .q_cfg(q_reg), .stat(stat), .t_out(m_surface_temp)
    );
endmodule

/* test/radiative_surface_temp_solver_unit_test.sv */
// Self-checking testbench for the radiative surface temperature solver unit.
module radiative_surface_temp_solver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STEPS = 32;
    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 50000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [27:0] surface_temp;
        logic        converged;
    } solution_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = rsts_pkg::REG_CONDUCTIVITY;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [27:0] s_inner_temp = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [27:0] m_surface_temp;
    logic        m_converged;

    logic [23:0] conductivity_reg;
    logic [31:0] depth_reg;
    logic [11:0] flux_reg;

    solution_t expected_solutions[$];
    int mismatch_count = 0;
    int solved_count = 0;
    int sent_count = 0;
    int converged_count = 0;
    int stall_cycles = 0;
    int ready_wait = 0;
    bit timed_out = 1'b0;

    radiative_surface_temp_solver_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_inner_temp(s_inner_temp),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_surface_temp(m_surface_temp), .m_converged(m_converged)
    );

    always #5 aclk = ~aclk;

    // Newton iteration on the surface balance with the block's truncations.
    function automatic solution_t solve_surface(logic [27:0] inner);
        logic [127:0] t, ti, depth, kd, qterm, t2, st2, rad, drad, dt, kterm;
        logic [127:0] slope, pos, neg, mag, step;
        logic done, down;
        solution_t r;
        ti = 128'(inner);
        t = ti;
        done = 1'b0;
        depth = (depth_reg == 0) ? 128'd1 : 128'(depth_reg);
        kd = (128'(conductivity_reg) << 40) / depth;
        qterm = 128'(flux_reg) << 48;
        for (int i = 0; i < MAX_STEPS; i++) begin
            t2 = t * t;
            st2 = (128'(rsts_pkg::SIGMA_Q64) * t2) >> (16 + 2 * FRAC);
            st2 = st2 & 128'hFFFF_FFFF_FFFF_FFFF;
            rad = (st2 * t2) >> (2 * FRAC);
            drad = (st2 * t) >> (FRAC - 2);
            dt = (t >= ti) ? t - ti : ti - t;
            kterm = (kd * dt) >> (FRAC - 8);
            slope = drad + (kd << 8);
            pos = rad;
            neg = qterm;
            if (t >= ti) pos = pos + kterm;
            else neg = neg + kterm;
            if (slope == 0) break;
            down = pos >= neg;
            mag = down ? pos - neg : neg - pos;
            step = (mag << FRAC) / slope;
            if (step == 0) begin
                done = 1'b1;
                break;
            end
            if (step > 128'(rsts_pkg::TEMP_MAX)) step = 128'(rsts_pkg::TEMP_MAX) + 128'd1;
            if (down) t = (step >= t) ? 128'd0 : t - step;
            else t = (t + step > 128'(rsts_pkg::TEMP_MAX)) ? 128'(rsts_pkg::TEMP_MAX) : t + step;
        end
        r.surface_temp = t[27:0];
        r.converged = done;
        return r;
    endfunction

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == rsts_pkg::REG_CONDUCTIVITY) conductivity_reg = value[23:0];
        else if (index == rsts_pkg::REG_HALF_CELL_DEPTH) depth_reg = value;
        else if (index == rsts_pkg::REG_ABSORBED_FLUX) flux_reg = value[11:0];
    endtask

    // Valid stays high after a transfer; the next call or wait_idle decides whether it drops.
    task automatic send_inner_temp(logic [27:0] value, bit may_idle = 1'b1);
        int gap;
        gap = may_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_inner_temp <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_solutions.push_back(solve_surface(value));
        sent_count++;
    endtask

    // Registers change only once the block has delivered every result.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_solutions.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [27:0] random_temp();
        case ($urandom_range(0, 3))
            0: return 28'($urandom_range(1, 32'h3FF_FFFF));
            1: return 28'($urandom_range(150, 400)) << FRAC | 28'($urandom_range(0, 65535));
            2: return 28'($urandom_range(1, 255));
            default: return 28'($urandom);
        endcase
    endfunction

    // Each result waits a drawn number of cycles before it is taken.
    always @(posedge aclk) begin
        int draw;
        draw = $urandom_range(0, 4);
        if (!aresetn || (m_valid && m_ready)) begin
            ready_wait <= draw;
            m_ready <= (draw == 0);
        end else if (m_valid && !m_ready) begin
            if (ready_wait <= 1) m_ready <= 1'b1;
            ready_wait <= ready_wait - 1;
        end
    end

    always @(posedge aclk) begin
        solution_t expected;
        if (aresetn && m_valid && m_ready) begin
            solved_count++;
            if (m_converged) converged_count++;
            if (expected_solutions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: temp %0d converged %0b",
                             m_surface_temp, m_converged);
            end else begin
                expected = expected_solutions.pop_front();
                if (m_surface_temp !== expected.surface_temp
                        || m_converged !== expected.converged) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: temp exp %0d got %0d, converged exp %0b got %0b",
                                 expected.surface_temp, m_surface_temp,
                                 expected.converged, m_converged);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("radiative_surface_temp_solver_unit verification failed");
            $finish;
        end
    end

    task automatic test_default_registers();
        send_inner_temp(28'd1, 1'b0);
        send_inner_temp(rsts_pkg::TEMP_MAX, 1'b0);
        send_inner_temp(28'd0);
        send_inner_temp(28'd270 << FRAC);
        send_inner_temp(28'h5555555);
        send_inner_temp(28'hAAAAAAA);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_register(rsts_pkg::REG_CONDUCTIVITY, 32'd0);
        write_register(rsts_pkg::REG_ABSORBED_FLUX, 32'd0);
        send_inner_temp(28'd0);
        send_inner_temp(28'd1);
        send_inner_temp(28'd300 << FRAC);
        wait_idle();
        write_register(rsts_pkg::REG_CONDUCTIVITY, 32'hFFFFFF);
        write_register(rsts_pkg::REG_HALF_CELL_DEPTH, 32'd0);
        write_register(rsts_pkg::REG_ABSORBED_FLUX, 32'hFFF);
        send_inner_temp(28'd1);
        send_inner_temp(rsts_pkg::TEMP_MAX);
        send_inner_temp(28'd250 << FRAC);
        wait_idle();
        write_register(rsts_pkg::REG_CONDUCTIVITY, 32'd1);
        write_register(rsts_pkg::REG_HALF_CELL_DEPTH, 32'hFFFFFFFF);
        send_inner_temp(28'd1);
        send_inner_temp(rsts_pkg::TEMP_MAX);
        send_inner_temp(28'd200 << FRAC);
        wait_idle();
        // Index three selects no register and must change nothing.
        write_register(REG_UNUSED, 32'hFFFFFFFF);
        write_register(rsts_pkg::REG_HALF_CELL_DEPTH, 32'd1);
        send_inner_temp(28'd1000 << FRAC);
        send_inner_temp(28'd5);
        wait_idle();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 15; phase++) begin
            write_register(rsts_pkg::REG_CONDUCTIVITY, (phase % 3 == 0)
                           ? $urandom_range(0, 24'hFFFFFF)
                           : $urandom_range(1 << 14, 20 << 16));
            write_register(rsts_pkg::REG_HALF_CELL_DEPTH, (phase % 4 == 0) ? $urandom
                           : $urandom_range(1 << 10, 8 << 16));
            write_register(rsts_pkg::REG_ABSORBED_FLUX, $urandom_range(0, 4095));
            for (int n = 0; n < 62; n++) send_inner_temp(random_temp());
            wait_idle();
        end
    endtask

    initial begin
        conductivity_reg = 24'd196608;
        depth_reg = 32'd65536;
        flux_reg = 12'd114;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_registers();
        test_register_extremes();
        test_random_settings();
        $display("Sent %0d inner temperatures over several register settings;", sent_count);
        $display("%0d results checked, %0d of them converged.", solved_count, converged_count);
        if (mismatch_count == 0 && expected_solutions.size() == 0)
            $display("radiative_surface_temp_solver_unit verification clean");
        else
            $display("radiative_surface_temp_solver_unit verification failed");
        $finish;
    end
endmodule
